>>> sv/ptcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcb_pkg
// Shared constants, types and helpers of the power trend chart binner.
// ----------------------------------------------------------------------------
package ptcb_pkg;

    localparam int COLUMNS = 47;
    localparam int HEIGHT  = 20;

    localparam int IDX_W   = $clog2(COLUMNS);
    localparam int COL_W   = $clog2(COLUMNS + 1);
    localparam int H_W     = $clog2(HEIGHT + 1);

    localparam int TS_W    = 32;
    localparam int PWR_W   = 20;
    localparam int SUM_W   = 36;
    localparam int CNT_W   = 16;
    localparam int DOT_W   = 16;
    localparam int GAP_W   = 20;
    localparam int TICK_W  = 16;
    localparam int ACC_W   = TICK_W + COL_W + 1;

    localparam int DVD_W   = SUM_W;
    localparam int DSR_W   = PWR_W + 1;
    localparam int NUM_W   = PWR_W + H_W + 2;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;

    localparam int OUT_COL_W = 6;
    localparam int OUT_HT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_DOT_PERIOD   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_AFTER  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_SPACING = 8'd3;

    localparam logic [DOT_W-1:0]  RST_DOT_PERIOD   = 16'd766;
    localparam logic [GAP_W-1:0]  RST_GAP_LIMIT    = 20'd14400;
    localparam logic [PWR_W-1:0]  RST_FLOOR_AFTER  = 20'd100;
    localparam logic [TICK_W-1:0] RST_TICK_SPACING = 16'd3600;
    localparam logic [PWR_W-1:0]  RST_PEAK         = 20'd200;
    localparam logic [CNT_W-1:0]  COUNT_MAX        = {CNT_W{1'b1}};

    typedef struct packed {
        logic latch_in;
        logic do_gap;
        logic do_period;
        logic start_avg;
        logic write_avg;
        logic do_acc;
        logic load_empty;
        logic mul;
        logic start_ht;
        logic load_out;
        logic col_next;
    } ptcb_cmd_t;

    typedef struct packed {
        logic gap_hit;
        logic period_hit;
        logic count_nz;
        logic div_done;
        logic fill_zero;
        logic last_col;
    } ptcb_status_t;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                  input logic [COL_W-1:0] off);
        logic [COL_W:0] sum;
        sum = {{(COL_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (COL_W + 1)'(COLUMNS))
            sum = sum - (COL_W + 1)'(COLUMNS);
        return sum[IDX_W-1:0];
    endfunction

endpackage

>>> sv/ptcb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcb_if
// Valid/ready channels: sample input, chart result output, register write.
// ----------------------------------------------------------------------------
interface ptcb_in_if;
    logic                        valid;
    logic                        ready;
    logic [ptcb_pkg::TS_W-1:0]   timestamp;
    logic [ptcb_pkg::PWR_W-1:0]  power_sample;
    modport source (output valid, timestamp, power_sample, input ready);
    modport sink   (input valid, timestamp, power_sample, output ready);
endinterface

interface ptcb_out_if;
    logic                           valid;
    logic                           ready;
    logic [ptcb_pkg::OUT_COL_W-1:0] column;
    logic [ptcb_pkg::OUT_HT_W-1:0]  height;
    logic                           hour_tick;
    logic                           point_valid;
    logic [ptcb_pkg::PWR_W-1:0]     peak_watts;
    logic                           last;
    modport source (output valid, column, height, hour_tick, point_valid, peak_watts, last,
                    input ready);
    modport sink   (input valid, column, height, hour_tick, point_valid, peak_watts, last,
                    output ready);
endinterface

interface ptcb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ptcb_pkg::CFG_IDX_W-1:0]    index;
    logic [ptcb_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/ptcb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcb_div
// Restoring divider, one quotient bit per cycle; done pulses when finished.
// ----------------------------------------------------------------------------
module ptcb_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ptcb_pkg::DVD_W-1:0] dividend,
    input  logic [ptcb_pkg::DSR_W-1:0] divisor,
    output logic                       done,
    output logic [ptcb_pkg::DVD_W-1:0] quotient
);
    localparam int DVD_W = ptcb_pkg::DVD_W;
    localparam int DSR_W = ptcb_pkg::DSR_W;
    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] q_reg, q_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W:0]   trial;
    logic             qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, q_reg[DVD_W-1]};
        qbit      = (trial >= {1'b0, dsr_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W - 1);
            rem_next  = '0;
            q_next    = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
            q_next   = {q_reg[DVD_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> sv/ptcb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcb_datapath
// Registers, accumulator, history ring memory, divider and result register.
// ----------------------------------------------------------------------------
module ptcb_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    ptcb_in_if.sink                samples,
    ptcb_out_if.source             results,
    ptcb_cfg_if.sink               cfg,
    input  ptcb_pkg::ptcb_cmd_t    cmd,
    output ptcb_pkg::ptcb_status_t status
);
    localparam int COLUMNS = ptcb_pkg::COLUMNS;
    localparam int IDX_W   = ptcb_pkg::IDX_W;
    localparam int COL_W   = ptcb_pkg::COL_W;
    localparam int TS_W    = ptcb_pkg::TS_W;
    localparam int PWR_W   = ptcb_pkg::PWR_W;
    localparam int SUM_W   = ptcb_pkg::SUM_W;
    localparam int CNT_W   = ptcb_pkg::CNT_W;
    localparam int DOT_W   = ptcb_pkg::DOT_W;
    localparam int GAP_W   = ptcb_pkg::GAP_W;
    localparam int TICK_W  = ptcb_pkg::TICK_W;
    localparam int ACC_W   = ptcb_pkg::ACC_W;
    localparam int DVD_W   = ptcb_pkg::DVD_W;
    localparam int DSR_W   = ptcb_pkg::DSR_W;
    localparam int NUM_W   = ptcb_pkg::NUM_W;
    localparam int H_W     = ptcb_pkg::H_W;
    localparam int OUT_COL_W_L = ptcb_pkg::OUT_COL_W;

    logic [DOT_W-1:0]  dot_reg;
    logic [GAP_W-1:0]  gap_reg;
    logic [PWR_W-1:0]  floor_reg;
    logic [TICK_W-1:0] tick_reg;

    logic [TS_W-1:0]   now_reg;
    logic [PWR_W-1:0]  smp_reg;
    logic [TS_W-1:0]   ps_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  base_reg;
    logic [COL_W-1:0]  fill_reg;
    logic [PWR_W-1:0]  peak_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ACC_W-1:0]  acci_reg;
    logic [ACC_W-1:0]  acct_reg;
    logic [PWR_W-1:0]  rd_reg;
    logic [NUM_W-1:0]  num_reg;

    logic [PWR_W-1:0]  mem [COLUMNS];

    logic [OUT_COL_W_L-1:0] o_col_reg;
    logic [ptcb_pkg::OUT_HT_W-1:0] o_ht_reg;
    logic              o_tick_reg;
    logic              o_pv_reg;
    logic [PWR_W-1:0]  o_peak_reg;
    logic              o_last_reg;

    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [DSR_W-1:0]  div_dsr;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;

    logic              tick_now;
    logic [H_W-1:0]    ht_sat;

    assign cfg.ready     = 1'b1;
    assign samples.ready = cmd.latch_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg   <= ptcb_pkg::RST_DOT_PERIOD;
            gap_reg   <= ptcb_pkg::RST_GAP_LIMIT;
            floor_reg <= ptcb_pkg::RST_FLOOR_AFTER;
            tick_reg  <= ptcb_pkg::RST_TICK_SPACING;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ptcb_pkg::REG_DOT_PERIOD:   dot_reg   <= cfg.data[DOT_W-1:0];
                ptcb_pkg::REG_GAP_LIMIT:    gap_reg   <= cfg.data[GAP_W-1:0];
                ptcb_pkg::REG_FLOOR_AFTER:  floor_reg <= cfg.data[PWR_W-1:0];
                ptcb_pkg::REG_TICK_SPACING: tick_reg  <= cfg.data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign status.gap_hit    = {1'b0, now_reg} > ({1'b0, ps_reg} + (TS_W + 1)'(gap_reg));
    assign status.period_hit = {1'b0, now_reg} >= ({1'b0, ps_reg} + (TS_W + 1)'(dot_reg));
    assign status.count_nz   = (cnt_reg != '0);
    assign status.div_done   = div_done;
    assign status.fill_zero  = (fill_reg == '0);
    assign status.last_col   = o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg   <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            base_reg <= '0;
            fill_reg <= '0;
            peak_reg <= ptcb_pkg::RST_PEAK;
            col_reg  <= '0;
            acci_reg <= '0;
            acct_reg <= '0;
        end
        else
        begin
            if (cmd.do_gap)
            begin
                sum_reg  <= '0;
                cnt_reg  <= '0;
                base_reg <= '0;
                fill_reg <= '0;
                peak_reg <= floor_reg;
                ps_reg   <= now_reg;
            end
            if (cmd.do_period)
            begin
                if (fill_reg >= COL_W'(COLUMNS))
                begin
                    base_reg <= ptcb_pkg::wrap_idx(base_reg, COL_W'(1));
                    fill_reg <= COL_W'(COLUMNS - 1);
                end
                ps_reg <= now_reg;
            end
            if (cmd.write_avg)
            begin
                fill_reg <= fill_reg + 1'b1;
                sum_reg  <= '0;
                cnt_reg  <= '0;
            end
            if (cmd.do_acc)
            begin
                if (cnt_reg != ptcb_pkg::COUNT_MAX)
                begin
                    sum_reg <= sum_reg + SUM_W'(smp_reg);
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (smp_reg > peak_reg)
                    peak_reg <= smp_reg;
                col_reg  <= '0;
                acci_reg <= '0;
                acct_reg <= ACC_W'(tick_reg);
            end
            if (cmd.load_out)
            begin
                acci_reg <= acci_reg + ACC_W'(dot_reg);
                if (tick_now)
                    acct_reg <= acct_reg + ACC_W'(tick_reg);
            end
            if (cmd.col_next)
                col_reg <= col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in && samples.valid)
        begin
            now_reg <= samples.timestamp;
            smp_reg <= samples.power_sample;
        end
        if (cmd.write_avg)
            mem[ptcb_pkg::wrap_idx(base_reg, fill_reg)] <= div_q[PWR_W-1:0];
        rd_reg <= mem[ptcb_pkg::wrap_idx(base_reg, col_reg)];
        if (cmd.mul)
            num_reg <= NUM_W'(rd_reg) * NUM_W'(2 * ptcb_pkg::HEIGHT) + NUM_W'(peak_reg);
    end

    assign div_start = cmd.start_avg | cmd.start_ht;
    assign div_dvd   = cmd.start_ht ? DVD_W'(num_reg) : sum_reg;
    assign div_dsr   = cmd.start_ht ? {peak_reg, 1'b0} : DSR_W'(cnt_reg);

    ptcb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    assign tick_now = (acci_reg > acct_reg);
    assign ht_sat   = (div_q > DVD_W'(ptcb_pkg::HEIGHT)) ? H_W'(ptcb_pkg::HEIGHT) : div_q[H_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_empty)
        begin
            o_col_reg  <= '0;
            o_ht_reg   <= '0;
            o_tick_reg <= 1'b0;
            o_pv_reg   <= 1'b0;
            o_peak_reg <= peak_reg;
            o_last_reg <= 1'b1;
        end
        else if (cmd.load_out)
        begin
            o_col_reg  <= OUT_COL_W_L'(col_reg);
            o_ht_reg   <= (peak_reg == '0) ? '0 : ptcb_pkg::OUT_HT_W'(ht_sat);
            o_tick_reg <= tick_now;
            o_pv_reg   <= 1'b1;
            o_peak_reg <= peak_reg;
            o_last_reg <= ((col_reg + 1'b1) == fill_reg);
        end
    end

    assign results.column      = o_col_reg;
    assign results.height      = o_ht_reg;
    assign results.hour_tick   = o_tick_reg;
    assign results.point_valid = o_pv_reg;
    assign results.peak_watts  = o_peak_reg;
    assign results.last        = o_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= COL_W'(COLUMNS))
        else $error("fill count beyond column count");
    a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg < IDX_W'(COLUMNS))
        else $error("ring base out of range");
    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_avg |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("append did not advance fill count");

endmodule

>>> sv/ptcb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcb_ctrl
// Sequencer: gap check, period close, accumulate, then the column walk.
// ----------------------------------------------------------------------------
module ptcb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   out_ready,
    output logic                   out_valid,
    input  ptcb_pkg::ptcb_status_t status,
    output ptcb_pkg::ptcb_cmd_t    cmd
);
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_GAP  = 10'b0000000010,
        S_PER  = 10'b0000000100,
        S_AVG  = 10'b0000001000,
        S_ACC  = 10'b0000010000,
        S_RD   = 10'b0000100000,
        S_MUL  = 10'b0001000000,
        S_HT   = 10'b0010000000,
        S_HW   = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch_in = 1'b1;
                if (in_valid)
                    state_next = S_GAP;
            end
            S_GAP:
            begin
                cmd.do_gap = status.gap_hit;
                state_next = S_PER;
            end
            S_PER:
            begin
                if (status.period_hit)
                begin
                    cmd.do_period = 1'b1;
                    cmd.start_avg = status.count_nz;
                    state_next    = status.count_nz ? S_AVG : S_ACC;
                end
                else
                    state_next = S_ACC;
            end
            S_AVG:
            begin
                if (status.div_done)
                begin
                    cmd.write_avg = 1'b1;
                    state_next    = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.do_acc = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                if (status.fill_zero)
                begin
                    cmd.load_empty = 1'b1;
                    state_next     = S_OUT;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_HT;
            end
            S_HT:
            begin
                cmd.start_ht = 1'b1;
                state_next   = S_HW;
            end
            S_HW:
            begin
                if (status.div_done)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.col_next = 1'b1;
                    state_next   = status.last_col ? S_IDLE : S_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign out_valid = (state_reg == S_OUT);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !cmd.latch_in)
        else $error("input taken while a word is pending");
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status.last_col) |=> state_reg == S_IDLE)
        else $error("walk did not end on last word");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("pending word dropped");

endmodule

>>> sv/power_trend_chart_binner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_trend_chart_binner
// Averages power samples into chart columns and reports the scaled history.
// ----------------------------------------------------------------------------
// samples: one word per (timestamp, power_sample). results: one word per
// stored column, in order, last set on the final one; an empty history gives
// a single word with point_valid low. cfg: register writes, always ready;
// the user must see them issued only while idle; the block does not enforce it.
// An input passes through setup, an average division when a period closes
// with samples, then a read, multiply, height division and output for each
// stored column. The single shared restoring divider, one quotient bit per
// cycle, does both divisions.
// samples is ready only between items. A stalled receiver holds the current
// word in the output register and the walk waits.
// Reset clears the accumulator and fill count, loads the peak with 200 and
// the registers with their defaults; history needs no clearing pass.
// ----------------------------------------------------------------------------
module power_trend_chart_binner (
    input  logic       clk,
    input  logic       rst_n,
    ptcb_in_if.sink    samples,
    ptcb_out_if.source results,
    ptcb_cfg_if.sink   cfg
);
    ptcb_pkg::ptcb_cmd_t    cmd;
    ptcb_pkg::ptcb_status_t status;
    logic                   out_valid;

    ptcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .out_ready (results.ready),
        .out_valid (out_valid),
        .status    (status),
        .cmd       (cmd)
    );

    ptcb_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status)
    );

    assign results.valid = out_valid;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the power trend chart binner: drives timestamp/power words,
// predicts every chart column word and compares each one as a whole word.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [ptcb_pkg::OUT_COL_W-1:0] column;
        logic [ptcb_pkg::OUT_HT_W-1:0]  height;
        logic                           hour_tick;
        logic                           point_valid;
        logic [ptcb_pkg::PWR_W-1:0]     peak_watts;
        logic                           last;
    } column_word_t;

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   mismatches;

    ptcb_in_if  samples ();
    ptcb_out_if results ();
    ptcb_cfg_if cfg ();

    power_trend_chart_binner DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .results (results.source),
        .cfg     (cfg.sink)
    );

    // chart state
    logic [ptcb_pkg::DOT_W-1:0]  m_dot;
    logic [ptcb_pkg::GAP_W-1:0]  m_gap;
    logic [ptcb_pkg::PWR_W-1:0]  m_floor;
    logic [ptcb_pkg::TICK_W-1:0] m_tick;
    logic [ptcb_pkg::TS_W-1:0]   m_start;
    logic [ptcb_pkg::SUM_W-1:0]  m_sum;
    logic [ptcb_pkg::CNT_W-1:0]  m_count;
    logic [ptcb_pkg::PWR_W-1:0]  m_hist [ptcb_pkg::COLUMNS];
    int                          m_fill;
    logic [ptcb_pkg::PWR_W-1:0]  m_peak;
    logic [ptcb_pkg::TS_W-1:0]   now_ts;

    column_word_t expected_columns [$];

    always #6 clk = ~clk;

    initial begin
        #50_000_000;
        $display("power_trend_chart_binner verification failed");
        $finish;
    end

    function automatic logic [ptcb_pkg::OUT_HT_W-1:0] chart_height(
        input logic [ptcb_pkg::PWR_W-1:0] v);
        longint unsigned num, den, h;
        if (m_peak == 0)
            return '0;
        num = 2 * longint'(v) * ptcb_pkg::HEIGHT + m_peak;
        den = 2 * longint'(m_peak);
        h = num / den;
        if (h > ptcb_pkg::HEIGHT)
            h = ptcb_pkg::HEIGHT;
        return h[ptcb_pkg::OUT_HT_W-1:0];
    endfunction

    task automatic chart_update(input logic [ptcb_pkg::TS_W-1:0] ts,
                                input logic [ptcb_pkg::PWR_W-1:0] pwr);
        column_word_t w;
        longint unsigned n;
        if (longint'(ts) > longint'(m_start) + m_gap) begin
            foreach (m_hist[i])
                m_hist[i] = '0;
            m_fill  = 0;
            m_sum   = '0;
            m_count = '0;
            m_peak  = m_floor;
            m_start = ts;
        end
        if (longint'(ts) >= longint'(m_start) + m_dot) begin
            if (m_fill >= ptcb_pkg::COLUMNS) begin
                for (int i = 0; i < ptcb_pkg::COLUMNS - 1; i++)
                    m_hist[i] = m_hist[i+1];
                m_fill = ptcb_pkg::COLUMNS - 1;
            end
            if (m_count != 0) begin
                m_hist[m_fill] = ptcb_pkg::PWR_W'(m_sum / m_count);
                m_fill++;
                m_sum   = '0;
                m_count = '0;
            end
            m_start = ts;
        end
        if (m_count != ptcb_pkg::COUNT_MAX) begin
            m_sum   = m_sum + pwr;
            m_count = m_count + 1'b1;
        end
        if (pwr > m_peak)
            m_peak = pwr;
        if (m_fill == 0) begin
            w = '0;
            w.peak_watts = m_peak;
            w.last = 1'b1;
            expected_columns.push_back(w);
            return;
        end
        n = 1;
        for (int i = 0; i < m_fill; i++) begin
            w = '0;
            if (longint'(i) * m_dot > longint'(m_tick) * n) begin
                w.hour_tick = 1'b1;
                n++;
            end
            w.column      = ptcb_pkg::OUT_COL_W'(i);
            w.height      = chart_height(m_hist[i]);
            w.point_valid = 1'b1;
            w.peak_watts  = m_peak;
            w.last        = (i + 1 == m_fill);
            expected_columns.push_back(w);
        end
    endtask

    task automatic send_sample(input logic [ptcb_pkg::TS_W-1:0] ts,
                               input logic [ptcb_pkg::PWR_W-1:0] pwr);
        while (!no_idle && $urandom_range(99) < 26) begin
            samples.valid <= 1'b0;
            @(negedge clk);
        end
        samples.valid        <= 1'b1;
        samples.timestamp    <= ts;
        samples.power_sample <= pwr;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        chart_update(ts, pwr);
        now_ts = ts;
        @(negedge clk);
    endtask

    task automatic step(input int dt, input logic [ptcb_pkg::PWR_W-1:0] pwr);
        longint unsigned t;
        t = longint'(now_ts) + dt;
        if (t > 32'hFFFF_FFFF)
            t = 32'hFFFF_FFFF;
        send_sample(ptcb_pkg::TS_W'(t), pwr);
    endtask

    task automatic drain;
        samples.valid <= 1'b0;
        while (expected_columns.size() != 0)
            @(negedge clk);
        repeat (2200) @(negedge clk);
    endtask

    task automatic write_reg(input logic [ptcb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ptcb_pkg::CFG_DATA_W-1:0] v);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            ptcb_pkg::REG_DOT_PERIOD:   m_dot   = v[ptcb_pkg::DOT_W-1:0];
            ptcb_pkg::REG_GAP_LIMIT:    m_gap   = v;
            ptcb_pkg::REG_FLOOR_AFTER:  m_floor = v;
            ptcb_pkg::REG_TICK_SPACING: m_tick  = v[ptcb_pkg::TICK_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic setup(input logic [ptcb_pkg::DOT_W-1:0] d,
                         input logic [ptcb_pkg::GAP_W-1:0] g,
                         input logic [ptcb_pkg::PWR_W-1:0] f,
                         input logic [ptcb_pkg::TICK_W-1:0] t);
        drain();
        write_reg(ptcb_pkg::REG_DOT_PERIOD, d);
        write_reg(ptcb_pkg::REG_GAP_LIMIT, g);
        write_reg(ptcb_pkg::REG_FLOOR_AFTER, f);
        write_reg(ptcb_pkg::REG_TICK_SPACING, t);
        cfg.valid <= 1'b0;
    endtask

    task automatic test_defaults;
        send_sample(32'd0, 20'd0);
        send_sample(32'd10, 20'hFFFFF);
        step(766, 20'd500);
        step(766, 20'd1000);
        step(-5, 20'd300);
        step(20000, 20'd50);
        step(800, 20'd0);
    endtask

    task automatic test_extremes;
        setup(16'd1, 20'hFFFFF, 20'd1, 16'hFFFF);
        for (int i = 0; i < 8; i++)
            step(1, ptcb_pkg::PWR_W'($urandom));
        setup(16'hFFFF, 20'd1, 20'hFFFFF, 16'd1);
        step(2, 20'd7);
        step(65535, 20'd9);
        step(0, 20'd0);
        send_sample(32'hFFFF_FFFF, 20'h55555);
        send_sample(32'hFFFF_FFFF, 20'hAAAAA);
    endtask

    task automatic test_full_history;
        setup(16'd3, 20'd100000, 20'd5000, 16'd7);
        send_sample(32'd100, 20'd0);
        now_ts = 32'd100;
        for (int i = 0; i < 55; i++)
            step((i % 5 == 0) ? 3 : 1, ptcb_pkg::PWR_W'($urandom_range(6000)));
    endtask

    task automatic test_long_period;
        setup(16'hFFFF, 20'hFFFFF, 20'd10, 16'd100);
        send_sample(32'd1000, 20'd1);
        no_idle = 1'b1;
        repeat (40) step(0, 20'hFFFFF);
        no_idle = 1'b0;
        step(65535, 20'd3);
    endtask

    task automatic test_random;
        int dt;
        for (int ph = 0; ph < 4; ph++) begin
            setup(ptcb_pkg::DOT_W'($urandom_range(1, 40)),
                  ptcb_pkg::GAP_W'($urandom_range(50, 3000)),
                  ptcb_pkg::PWR_W'($urandom_range(1, 1000)),
                  ptcb_pkg::TICK_W'($urandom_range(1, 60)));
            no_idle = (ph == 2);
            for (int i = 0; i < 50; i++) begin
                case ($urandom_range(9))
                    0: dt = -$urandom_range(5);
                    1: dt = $urandom_range(4000);
                    default: dt = $urandom_range(12);
                endcase
                step(dt, ($urandom_range(5) == 0) ? ptcb_pkg::PWR_W'($urandom) :
                                                    ptcb_pkg::PWR_W'($urandom_range(2000)));
            end
        end
        no_idle = 1'b0;
    endtask

    // result checker
    initial begin
        results.ready <= 1'b0;
        forever begin
            @(negedge clk);
            results.ready <= no_idle || ($urandom_range(99) >= 26);
        end
    end

    always @(posedge clk) begin
        column_word_t got, want;
        if (rst_n && results.valid && results.ready) begin
            got = '{results.column, results.height, results.hour_tick,
                    results.point_valid, results.peak_watts, results.last};
            if (expected_columns.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %p", got);
            end else begin
                want = expected_columns.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    initial begin
        clk = 1'b0;
        mismatches = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        samples.valid = 1'b0;
        samples.timestamp = '0;
        samples.power_sample = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        m_dot = ptcb_pkg::RST_DOT_PERIOD;
        m_gap = ptcb_pkg::RST_GAP_LIMIT;
        m_floor = ptcb_pkg::RST_FLOOR_AFTER;
        m_tick = ptcb_pkg::RST_TICK_SPACING;
        m_start = '0;
        m_sum = '0;
        m_count = '0;
        foreach (m_hist[i])
            m_hist[i] = '0;
        m_fill = 0;
        m_peak = ptcb_pkg::RST_PEAK;
        now_ts = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_defaults();
        test_full_history();
        test_long_period();
        test_random();
        test_extremes();
        drain();
        if (mismatches == 0 && expected_columns.size() == 0)
            $display("power_trend_chart_binner verification clean");
        else
            $display("power_trend_chart_binner verification failed");
        $finish;
    end
endmodule
